[rtl/rktab_pkg.sv]
// ----------------------------------------------------------------------------
// rktab_pkg
// Shared types and constants for the reference-counted key table.
// ----------------------------------------------------------------------------
package rktab_pkg;

  // Default sizes of the table.
  localparam int unsigned EntriesDef   = 32;
  localparam int unsigned KeyBitsDef   = 64;
  localparam int unsigned CountBitsDef = 16;

  // Fixed field widths on the stream ports.
  localparam int unsigned KeyFieldW   = 64;
  localparam int unsigned CountFieldW = 16;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned STdataW     = 72;
  localparam int unsigned MTdataW     = 24;

  // Operation codes.
  localparam logic OpInsert = 1'b0;
  localparam logic OpRemove = 1'b1;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_IN_USE    = 2'd3
  } status_e;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic compare;
    logic update;
    logic op;
    logic any_hit;
  } cell_cmd_t;

  // Flags rippled from cell to cell, lowest entry first.
  typedef struct packed {
    logic hit;
    logic free;
  } cell_chain_t;

endpackage

[rtl/rktab_cell.sv]
// ----------------------------------------------------------------------------
// rktab_cell
// One table entry: valid mark, key and reference count, with its own key
// comparator and its link in the priority chain.
// ----------------------------------------------------------------------------
module rktab_cell #(
  parameter int unsigned KEY_BITS   = rktab_pkg::KeyBitsDef,
  parameter int unsigned COUNT_BITS = rktab_pkg::CountBitsDef
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  rktab_pkg::cell_cmd_t    cmd_i,
  input  logic [KEY_BITS-1:0]     key_i,
  input  rktab_pkg::cell_chain_t  chain_i,
  output rktab_pkg::cell_chain_t  chain_o,
  input  logic [COUNT_BITS-1:0]   cnt_i,
  output logic [COUNT_BITS-1:0]   cnt_o
);
  import rktab_pkg::*;

  localparam logic [COUNT_BITS-1:0] CountMax = '1;
  localparam logic [COUNT_BITS-1:0] CountOne = COUNT_BITS'(1);

  logic                  valid_q, valid_d;
  logic [KEY_BITS-1:0]   key_q, key_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic                  hit_q, hit_d;
  logic                  claim;
  logic                  touched;

  // The lowest free entry claims the key when an insert found no match.
  assign claim = cmd_i.update && (cmd_i.op == OpInsert) && !cmd_i.any_hit &&
                 !valid_q && !chain_i.free;

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    count_d = count_q;
    hit_d   = hit_q;
    touched = 1'b0;
    if (cmd_i.compare) begin
      hit_d = valid_q && (key_q == key_i);
    end
    if (cmd_i.update && hit_q) begin
      touched = 1'b1;
      if (cmd_i.op == OpInsert) begin
        if (count_q != CountMax) begin
          count_d = count_q + CountOne;
        end
      end else if (count_q > CountOne) begin
        count_d = count_q - CountOne;
      end else begin
        valid_d = 1'b0;
        count_d = '0;
      end
    end else if (claim) begin
      touched = 1'b1;
      valid_d = 1'b1;
      key_d   = key_i;
      count_d = CountOne;
    end
  end

  assign chain_o.hit  = chain_i.hit | hit_q;
  assign chain_o.free = chain_i.free | ~valid_q;
  assign cnt_o        = cnt_i | (touched ? count_d : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      count_q <= '0;
      hit_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      count_q <= count_d;
      hit_q   <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

endmodule

[rtl/refcounted_key_table_unit.sv]
// ----------------------------------------------------------------------------
// refcounted_key_table_unit
// Reference-counted key table built as a row of entry cells.
// ----------------------------------------------------------------------------
// For each request, in the cycle its transfer is accepted the key is compared
// against every cell at once and the match is registered; in the update state
// the row is updated, with the lowest free entry found by a flag that ripples
// from cell to cell, and the result is loaded into the output register. The
// update waits while the output register still holds an untaken result, and a
// new request is taken only once the update is done.
module refcounted_key_table_unit #(
  parameter int unsigned ENTRIES    = rktab_pkg::EntriesDef,
  parameter int unsigned KEY_BITS   = rktab_pkg::KeyBitsDef,
  parameter int unsigned COUNT_BITS = rktab_pkg::CountBitsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // operation [0], entry_key [64:1], zero fill [71:65]
  input  logic [rktab_pkg::STdataW-1:0] s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // status [1:0], count_after [17:2], zero fill [23:18]
  output logic [rktab_pkg::MTdataW-1:0] m_axis_tdata
);
  import rktab_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_UPDATE
  } state_e;

  state_e                state_q;
  logic                  op_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [KEY_BITS-1:0]   in_key;
  logic                  in_fire;
  logic                  out_free;
  logic                  do_update;
  logic                  out_valid_q;
  status_e               status_q, status_d;
  logic [CountFieldW-1:0] count_out_q, count_out_d;
  logic [31:0]           count_wide;

  cell_cmd_t             cmd;
  cell_chain_t           chain [ENTRIES+1];
  logic [COUNT_BITS-1:0] cnt   [ENTRIES+1];

  assign in_key        = KEY_BITS'(s_axis_tdata[KeyFieldW:1]);
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign do_update     = (state_q == S_UPDATE) && out_free;

  assign cmd.compare = in_fire;
  assign cmd.update  = do_update;
  assign cmd.op      = op_q;
  assign cmd.any_hit = chain[ENTRIES].hit;

  assign chain[0] = '0;
  assign cnt[0]   = '0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    rktab_cell #(
      .KEY_BITS  (KEY_BITS),
      .COUNT_BITS(COUNT_BITS)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd),
      .key_i  ((state_q == S_IDLE) ? in_key : key_q),
      .chain_i(chain[i]),
      .chain_o(chain[i+1]),
      .cnt_i  (cnt[i]),
      .cnt_o  (cnt[i+1])
    );
  end

  assign count_wide  = 32'(cnt[ENTRIES]);
  assign count_out_d = count_wide[CountFieldW-1:0];

  always_comb begin
    status_d = ST_OK;
    if (op_q == OpInsert) begin
      if (!chain[ENTRIES].hit && !chain[ENTRIES].free) begin
        status_d = ST_FULL;
      end
    end else if (!chain[ENTRIES].hit) begin
      status_d = ST_NOT_FOUND;
    end else if (cnt[ENTRIES] != '0) begin
      status_d = ST_IN_USE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            state_q <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (do_update) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
      if (do_update) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q  <= s_axis_tdata[0];
      key_q <= in_key;
    end
    if (do_update) begin
      status_q    <= status_d;
      count_out_q <= count_out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(MTdataW - StatusW - CountFieldW)'(0), count_out_q, status_q};

endmodule

[rtl/rktab_checker.sv]
// ----------------------------------------------------------------------------
// rktab_checker
// Port-level checks for the reference-counted key table, bound to the top.
// ----------------------------------------------------------------------------
module rktab_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic [rktab_pkg::STdataW-1:0] s_axis_tdata,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [rktab_pkg::MTdataW-1:0] m_axis_tdata
);
  import rktab_pkg::*;

  logic       s_fire;
  logic [1:0] st;
  logic [15:0] cnt;

  assign s_fire = s_axis_tvalid && s_axis_tready;
  assign st     = m_axis_tdata[1:0];
  assign cnt    = m_axis_tdata[17:2];

  // A request occupies the block for its update cycle.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> !s_axis_tready)
    else $error("input taken again right after a transfer");

  // With room at the output, the result shows in the cycle after the update cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire ##1 (!m_axis_tvalid || m_axis_tready) |=> m_axis_tvalid)
    else $error("result missing after request");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed while stalled");

  // Full and not found carry no count, still in use always does.
  a_status_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (((st == ST_FULL) || (st == ST_NOT_FOUND)) ? (cnt == 16'd0) :
                       (st == ST_IN_USE) ? (cnt != 16'd0) : 1'b1))
    else $error("status and count disagree");

endmodule

bind refcounted_key_table_unit rktab_checker u_rktab_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
